@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
	else $error("assertion failed");

// Concurrent check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
	else $error("assertion failed");

`endif

@@ rtl/ncocic_pkg.sv @@
// Types, constants and helpers shared by the down-converter modules.
`default_nettype none

package ncocic_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int PROD_W     = 32;
	localparam int ACC_W      = 32;
	localparam int SLOT_W     = 9;
	localparam int POS_W      = 10;
	localparam int GAIN_W     = 3;
	localparam int WPO_W      = 9;
	localparam int SHIFT_W    = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OFFSET_FIRST     = 2'd0,
		REG_OFFSET_SECOND    = 2'd1,
		REG_GAIN_BITS        = 2'd2,
		REG_WORDS_PER_OUTPUT = 2'd3
	} reg_idx_t;

	// input beat operations
	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_PROCESS = 1'b1
	} op_t;

	// per-stage control: a word is present, and it closes a decimation block
	typedef struct packed {
		logic vld;
		logic dump;
	} beat_ctl_t;

	// clamp a signed value to the 16-bit range
	function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [31:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (v > 32'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -32'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/nco_mix_cic3_decimator.sv @@
// Top level: configuration registers, mixer and CIC pipeline, output scaling register.
//
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_stall    operation, sample_first, sample_second,
//                                              table_slot, osc_first, osc_second
//  out       source     out_valid / out_stall  filtered, position
//  cfg       sink       cfg_write              cfg_index, cfg_data
//
// One beat (load or sample word) is taken per cycle while in_stall is low; a result follows the
// word that closes its block through the table read, multiply, three integrator and three
// comb stages and the scaling register. Reset clears integrators, comb delays, counters and
// pipeline valid flags; the NCO table is not cleared. A held result under out_stall freezes
// the whole pipeline, and in_stall follows for exactly those cycles.
`default_nettype none

module nco_mix_cic3_decimator #(
	parameter int OSC_WORDS = 512,
	parameter int OUT_DEPTH = 1024
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    in_valid,
	output logic                                         in_stall,
	input  wire logic                                    operation,
	input  wire logic signed [ncocic_pkg::SAMPLE_W-1:0]  sample_first,
	input  wire logic signed [ncocic_pkg::SAMPLE_W-1:0]  sample_second,
	input  wire logic        [ncocic_pkg::SLOT_W-1:0]    table_slot,
	input  wire logic signed [ncocic_pkg::SAMPLE_W-1:0]  osc_first,
	input  wire logic signed [ncocic_pkg::SAMPLE_W-1:0]  osc_second,
	output logic                                         out_valid,
	input  wire logic                                    out_stall,
	output logic signed      [ncocic_pkg::SAMPLE_W-1:0]  filtered,
	output logic             [ncocic_pkg::POS_W-1:0]     position,
	input  wire logic                                    cfg_write,
	input  wire logic        [ncocic_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic        [ncocic_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int OW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
	localparam int SW = ncocic_pkg::SAMPLE_W;

	logic signed [SW-1:0]                  offset_first_q;
	logic signed [SW-1:0]                  offset_second_q;
	logic [ncocic_pkg::GAIN_W-1:0]         gain_bits_q;
	logic [ncocic_pkg::WPO_W-1:0]          words_per_output_q;
	logic [OW-1:0]                         out_slot_q;
	logic                                  out_valid_q;
	logic signed [SW-1:0]                  filtered_q;
	logic [ncocic_pkg::POS_W-1:0]          position_q;
	logic                                  adv;
	logic                                  take;
	ncocic_pkg::beat_ctl_t                 ctl_s2;
	logic signed [ncocic_pkg::PROD_W-1:0]  p1_s2;
	logic signed [ncocic_pkg::PROD_W-1:0]  p2_s2;
	logic                                  cv_s8;
	logic [ncocic_pkg::ACC_W-1:0]          e2_s8;
	logic [ncocic_pkg::SHIFT_W-1:0]        shift;
	logic signed [ncocic_pkg::ACC_W-1:0]   shifted;

	// pipeline moves unless a held result is stalled
	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;
	assign take     = in_valid && adv;

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;
	assign position  = position_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_first_q     <= '0;
			offset_second_q    <= '0;
			gain_bits_q        <= ncocic_pkg::GAIN_W'(5);
			words_per_output_q <= ncocic_pkg::WPO_W'(8);
		end else if (cfg_write) begin
			unique case (ncocic_pkg::reg_idx_t'(cfg_index))
				ncocic_pkg::REG_OFFSET_FIRST: begin
					offset_first_q <= $signed(cfg_data[SW-1:0]);
				end
				ncocic_pkg::REG_OFFSET_SECOND: begin
					offset_second_q <= $signed(cfg_data[SW-1:0]);
				end
				ncocic_pkg::REG_GAIN_BITS: begin
					gain_bits_q <= cfg_data[ncocic_pkg::GAIN_W-1:0];
				end
				ncocic_pkg::REG_WORDS_PER_OUTPUT: begin
					words_per_output_q <= cfg_data[ncocic_pkg::WPO_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	ncocic_mix #(
		.OSC_WORDS(OSC_WORDS)
	) u_mix (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (adv),
		.take            (take),
		.operation       (operation),
		.sample_first    (sample_first),
		.sample_second   (sample_second),
		.table_slot      (table_slot),
		.osc_first       (osc_first),
		.osc_second      (osc_second),
		.offset_first    (offset_first_q),
		.offset_second   (offset_second_q),
		.words_per_output(words_per_output_q),
		.ctl_s2          (ctl_s2),
		.p1_s2           (p1_s2),
		.p2_s2           (p2_s2)
	);

	ncocic_cic u_cic (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.ctl_s2(ctl_s2),
		.p1_s2 (p1_s2),
		.p2_s2 (p2_s2),
		.cv_s8 (cv_s8),
		.e2_s8 (e2_s8)
	);

	// scale the comb result by shifting it right by 16 minus the gain bits
	assign shift   = ncocic_pkg::SHIFT_W'(16) - ncocic_pkg::SHIFT_W'(gain_bits_q);
	assign shifted = $signed(e2_s8) >>> shift;

	// output beat register and slot counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_slot_q  <= '0;
		end else if (adv) begin
			out_valid_q <= cv_s8;
			if (cv_s8) begin
				out_slot_q <= (out_slot_q == OW'(OUT_DEPTH - 1)) ? '0 : out_slot_q + OW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && cv_s8) begin
			filtered_q <= ncocic_pkg::sat16(shifted);
			position_q <= ncocic_pkg::POS_W'(out_slot_q);
		end
	end

endmodule

`default_nettype wire

@@ rtl/ncocic_mix.sv @@
// NCO table memory, offset removal, phase and block counters, and mixer products.
`default_nettype none

module ncocic_mix #(
	parameter int OSC_WORDS = 512
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      adv,
	input  wire logic                                      take,
	input  wire logic                                      operation,
	input  wire logic signed [ncocic_pkg::SAMPLE_W-1:0]    sample_first,
	input  wire logic signed [ncocic_pkg::SAMPLE_W-1:0]    sample_second,
	input  wire logic        [ncocic_pkg::SLOT_W-1:0]      table_slot,
	input  wire logic signed [ncocic_pkg::SAMPLE_W-1:0]    osc_first,
	input  wire logic signed [ncocic_pkg::SAMPLE_W-1:0]    osc_second,
	input  wire logic signed [ncocic_pkg::SAMPLE_W-1:0]    offset_first,
	input  wire logic signed [ncocic_pkg::SAMPLE_W-1:0]    offset_second,
	input  wire logic        [ncocic_pkg::WPO_W-1:0]       words_per_output,
	output ncocic_pkg::beat_ctl_t                          ctl_s2,
	output logic signed      [ncocic_pkg::PROD_W-1:0]      p1_s2,
	output logic signed      [ncocic_pkg::PROD_W-1:0]      p2_s2
);

	localparam int PW = (OSC_WORDS > 1) ? $clog2(OSC_WORDS) : 1;
	localparam int SW = ncocic_pkg::SAMPLE_W;

	logic [2*SW-1:0]                  osc_mem [0:OSC_WORDS-1];
	logic [2*SW-1:0]                  rd_s1;
	logic [PW-1:0]                    phase_q;
	logic [ncocic_pkg::WPO_W-1:0]     count_q;
	logic [ncocic_pkg::WPO_W-1:0]     count_next;
	logic                             dump_now;
	logic                             is_proc;
	logic                             is_load;
	logic                             slot_ok;
	logic signed [SW:0]               diff1;
	logic signed [SW:0]               diff2;
	logic signed [SW-1:0]             a1_s1;
	logic signed [SW-1:0]             a2_s1;
	logic signed [SW-1:0]             osc_lo;
	logic signed [SW-1:0]             osc_hi;
	ncocic_pkg::beat_ctl_t            ctl_s1;

	// decode the beat
	assign is_proc = take && (operation == ncocic_pkg::OP_PROCESS);
	assign is_load = take && (operation == ncocic_pkg::OP_LOAD);
	assign slot_ok = 32'(table_slot) < 32'(OSC_WORDS);

	// block counter: a word closes the block once the count reaches the setting
	assign count_next = count_q + ncocic_pkg::WPO_W'(1);
	assign dump_now   = count_next >= words_per_output;

	// remove the DC offsets with saturation
	assign diff1 = (SW+1)'(sample_first) - (SW+1)'(offset_first);
	assign diff2 = (SW+1)'(sample_second) - (SW+1)'(offset_second);

	assign osc_lo = $signed(rd_s1[SW-1:0]);
	assign osc_hi = $signed(rd_s1[2*SW-1:SW]);

	// table: write on a load, read the current phase on a sample word
	always_ff @(posedge clk) begin
		if (is_load && slot_ok) begin
			osc_mem[PW'(table_slot)] <= {osc_second, osc_first};
		end
		if (is_proc) begin
			rd_s1 <= osc_mem[phase_q];
		end
	end

	// advance phase, block count and stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			count_q <= '0;
			ctl_s1  <= '0;
			ctl_s2  <= '0;
		end else begin
			if (is_proc) begin
				phase_q <= (phase_q == PW'(OSC_WORDS - 1)) ? '0 : phase_q + PW'(1);
				count_q <= dump_now ? '0 : count_next;
			end
			if (adv) begin
				ctl_s1 <= '{vld: is_proc, dump: is_proc && dump_now};
				ctl_s2 <= ctl_s1;
			end
		end
	end

	// corrected samples, then the two mixer products
	always_ff @(posedge clk) begin
		if (adv) begin
			a1_s1 <= ncocic_pkg::sat16(32'(diff1));
			a2_s1 <= ncocic_pkg::sat16(32'(diff2));
			p1_s2 <= ncocic_pkg::PROD_W'(a1_s1) * ncocic_pkg::PROD_W'(osc_lo);
			p2_s2 <= ncocic_pkg::PROD_W'(a2_s1) * ncocic_pkg::PROD_W'(osc_hi);
		end
	end

endmodule

`default_nettype wire

@@ rtl/ncocic_cic.sv @@
// Third-order CIC: skewed integrator chain and comb chain, one adder per stage, two in the first integrator.
`default_nettype none

module ncocic_cic (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  adv,
	input  wire ncocic_pkg::beat_ctl_t                 ctl_s2,
	input  wire logic signed [ncocic_pkg::PROD_W-1:0]  p1_s2,
	input  wire logic signed [ncocic_pkg::PROD_W-1:0]  p2_s2,
	output logic                                       cv_s8,
	output logic             [ncocic_pkg::ACC_W-1:0]   e2_s8
);

	localparam int AW = ncocic_pkg::ACC_W;

	logic [AW-1:0]          integ_one_q;
	logic [AW-1:0]          integ_two_q;
	logic [AW-1:0]          integ_three_q;
	logic [AW-1:0]          comb_one_q;
	logic [AW-1:0]          comb_two_q;
	logic [AW-1:0]          comb_three_q;
	logic [AW-1:0]          e0_s6;
	logic [AW-1:0]          e1_s7;
	ncocic_pkg::beat_ctl_t  ctl_s3;
	ncocic_pkg::beat_ctl_t  ctl_s4;
	logic                   cv_s5;
	logic                   cv_s6;
	logic                   cv_s7;

	// integrators and comb delays: each stage consumes its word in order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_one_q   <= '0;
			integ_two_q   <= '0;
			integ_three_q <= '0;
			comb_one_q    <= '0;
			comb_two_q    <= '0;
			comb_three_q  <= '0;
			ctl_s3        <= '0;
			ctl_s4        <= '0;
			cv_s5         <= 1'b0;
			cv_s6         <= 1'b0;
			cv_s7         <= 1'b0;
			cv_s8         <= 1'b0;
		end else if (adv) begin
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			cv_s5  <= ctl_s4.vld && ctl_s4.dump;
			cv_s6  <= cv_s5;
			cv_s7  <= cv_s6;
			cv_s8  <= cv_s7;
			if (ctl_s2.vld) begin
				integ_one_q <= integ_one_q + $unsigned(p1_s2) + $unsigned(p2_s2);
			end
			if (ctl_s3.vld) begin
				integ_two_q <= integ_two_q + integ_one_q;
			end
			if (ctl_s4.vld) begin
				integ_three_q <= integ_three_q + integ_two_q;
			end
			if (cv_s5) begin
				comb_one_q <= integ_three_q;
			end
			if (cv_s6) begin
				comb_two_q <= e0_s6;
			end
			if (cv_s7) begin
				comb_three_q <= e1_s7;
			end
		end
	end

	// comb differences
	always_ff @(posedge clk) begin
		if (adv) begin
			if (cv_s5) begin
				e0_s6 <= comb_one_q - integ_three_q;
			end
			if (cv_s6) begin
				e1_s7 <= comb_two_q - e0_s6;
			end
			if (cv_s7) begin
				e2_s8 <= comb_three_q - e1_s7;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/ncocic_checker.sv @@
// Port-level checks for the down-converter, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module ncocic_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [15:0] filtered,
	input wire logic [9:0]  position
);

	// a stalled result beat holds
	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(filtered) && $stable(position))

	// input backpressure only while a result beat is held
	`ASSERT_ALWAYS(a_in_stall_cause, clk, in_stall |-> out_valid && out_stall)

	// no result beat during reset
	`ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !out_valid)

	// back-to-back results take consecutive slots
	`ASSERT_CLK(a_slot_step, clk, arst_n, out_valid && !out_stall ##1 out_valid |-> position == 10'($past(position) + 10'd1) || position == 10'd0)

endmodule

bind nco_mix_cic3_decimator ncocic_checker u_ncocic_checker (.*);

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the NCO mixer and CIC3 decimator with a bit-true predictor.
module testbench;

	localparam int OSC_WORDS      = 512;
	localparam int OUT_DEPTH      = 1024;
	localparam int DRAIN_CYCLES   = 16;
	localparam int HOLD_OFF       = 200;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int N_DIRECTED     = 21;
	localparam int N_SETTINGS     = 7;

	// short names for the two operations in the stimulus table
	localparam ncocic_pkg::op_t LD_OP = ncocic_pkg::OP_LOAD;
	localparam ncocic_pkg::op_t PR_OP = ncocic_pkg::OP_PROCESS;

	typedef struct packed {
		logic signed [ncocic_pkg::SAMPLE_W-1:0] filt;
		logic        [ncocic_pkg::POS_W-1:0]    pos;
	} dec_out_t;

	// one directed beat; has_exp marks rows whose result is typed in
	typedef struct packed {
		ncocic_pkg::op_t                 op;
		logic [ncocic_pkg::SAMPLE_W-1:0] s1;
		logic [ncocic_pkg::SAMPLE_W-1:0] s2;
		logic [ncocic_pkg::SLOT_W-1:0]   slot;
		logic [ncocic_pkg::SAMPLE_W-1:0] o1;
		logic [ncocic_pkg::SAMPLE_W-1:0] o2;
		logic                            has_exp;
		logic [ncocic_pkg::SAMPLE_W-1:0] exp_f;
		logic [ncocic_pkg::POS_W-1:0]    exp_p;
	} beat_row_t;

	// one register setting; rnd draws offsets, gain and a short block at run time
	typedef struct packed {
		logic [ncocic_pkg::SAMPLE_W-1:0] ofs1;
		logic [ncocic_pkg::SAMPLE_W-1:0] ofs2;
		logic [ncocic_pkg::GAIN_W-1:0]   gain;
		logic [ncocic_pkg::WPO_W-1:0]    wpo;
		logic                            rnd;
		logic                            press;
	} setting_t;

	// Zero table entries first, so the first block of eight words must come out as zero
	// at slot zero; load fields of process words point at slots read later on.
	localparam beat_row_t DIRECTED [N_DIRECTED] = '{
		'{LD_OP, 16'h7fff, 16'h8000, 9'd0,   16'h0000, 16'h0000, 1'b0, 16'h0, 10'd0},
		'{LD_OP, 16'h8000, 16'h7fff, 9'd1,   16'h0000, 16'h0000, 1'b0, 16'h0, 10'd0},
		'{LD_OP, 16'hffff, 16'h0001, 9'd2,   16'h0000, 16'h0000, 1'b0, 16'h0, 10'd0},
		'{LD_OP, 16'h0000, 16'h0000, 9'd3,   16'h0000, 16'h0000, 1'b0, 16'h0, 10'd0},
		'{LD_OP, 16'h5555, 16'haaaa, 9'd4,   16'h0000, 16'h0000, 1'b0, 16'h0, 10'd0},
		'{LD_OP, 16'haaaa, 16'h5555, 9'd5,   16'h0000, 16'h0000, 1'b0, 16'h0, 10'd0},
		'{LD_OP, 16'h1234, 16'hedcb, 9'd6,   16'h0000, 16'h0000, 1'b0, 16'h0, 10'd0},
		'{LD_OP, 16'h0001, 16'hffff, 9'd7,   16'h0000, 16'h0000, 1'b0, 16'h0, 10'd0},
		'{LD_OP, 16'h2468, 16'h1357, 9'd511, 16'h7fff, 16'h8000, 1'b0, 16'h0, 10'd0},
		'{PR_OP, 16'h7fff, 16'h8000, 9'd511, 16'h8000, 16'h7fff, 1'b0, 16'h0, 10'd0},
		'{PR_OP, 16'h8000, 16'h7fff, 9'd8,   16'h1111, 16'h2222, 1'b0, 16'h0, 10'd0},
		'{PR_OP, 16'h0000, 16'h0000, 9'd9,   16'h7fff, 16'h7fff, 1'b0, 16'h0, 10'd0},
		'{PR_OP, 16'hffff, 16'h0001, 9'd10,  16'h8000, 16'h8000, 1'b0, 16'h0, 10'd0},
		'{PR_OP, 16'h7fff, 16'h7fff, 9'd255, 16'hffff, 16'hffff, 1'b0, 16'h0, 10'd0},
		'{PR_OP, 16'h8000, 16'h8000, 9'd256, 16'h0001, 16'h0001, 1'b0, 16'h0, 10'd0},
		'{PR_OP, 16'h1234, 16'hedcc, 9'd100, 16'h4000, 16'hc000, 1'b0, 16'h0, 10'd0},
		'{PR_OP, 16'h5a5a, 16'ha5a5, 9'd12,  16'h3333, 16'hcccc, 1'b1, 16'h0, 10'd0},
		'{LD_OP, 16'h7fff, 16'h7fff, 9'd8,   16'h8000, 16'h8000, 1'b0, 16'h0, 10'd0},
		'{LD_OP, 16'h8000, 16'h8000, 9'd9,   16'h7fff, 16'h7fff, 1'b0, 16'h0, 10'd0},
		'{PR_OP, 16'h8000, 16'h8000, 9'd511, 16'h0f0f, 16'hf0f0, 1'b0, 16'h0, 10'd0},
		'{PR_OP, 16'h7fff, 16'h8000, 9'd13,  16'h00ff, 16'hff00, 1'b0, 16'h0, 10'd0}
	};

	// Settings walked after the directed beats: the long hold-off runs with one word per
	// output; a block of 300 is followed by a block of 5 to lower the count under the wire.
	localparam setting_t SETTINGS [N_SETTINGS] = '{
		'{16'h1234, 16'hf800, 3'd6, 9'd1,   1'b0, 1'b1},
		'{16'h8000, 16'h7fff, 3'd0, 9'd256, 1'b0, 1'b0},
		'{16'h7fff, 16'h8000, 3'd7, 9'd0,   1'b0, 1'b0},
		'{16'h0400, 16'hfc00, 3'd3, 9'd300, 1'b0, 1'b0},
		'{16'h0000, 16'h0000, 3'd4, 9'd5,   1'b0, 1'b0},
		'{16'h0000, 16'h0000, 3'd0, 9'd1,   1'b1, 1'b0},
		'{16'h0000, 16'h0000, 3'd0, 9'd1,   1'b1, 1'b0}
	};

	logic                                   clk;
	logic                                   arst_n;
	logic                                   in_valid;
	logic                                   in_stall;
	ncocic_pkg::op_t                        operation;
	logic signed [ncocic_pkg::SAMPLE_W-1:0] sample_first;
	logic signed [ncocic_pkg::SAMPLE_W-1:0] sample_second;
	logic [ncocic_pkg::SLOT_W-1:0]          table_slot;
	logic signed [ncocic_pkg::SAMPLE_W-1:0] osc_first;
	logic signed [ncocic_pkg::SAMPLE_W-1:0] osc_second;
	logic                                   out_valid;
	logic                                   out_stall;
	logic signed [ncocic_pkg::SAMPLE_W-1:0] filtered;
	logic [ncocic_pkg::POS_W-1:0]           position;
	logic                                   cfg_write;
	ncocic_pkg::reg_idx_t                   cfg_index;
	logic [ncocic_pkg::CFG_DATA_W-1:0]      cfg_data;

	// predictor state
	logic signed [ncocic_pkg::SAMPLE_W-1:0] ofs_first;
	logic signed [ncocic_pkg::SAMPLE_W-1:0] ofs_second;
	logic [ncocic_pkg::GAIN_W-1:0]          gain_sel;
	logic [ncocic_pkg::WPO_W-1:0]           block_words;
	logic [ncocic_pkg::ACC_W-1:0]           integ1, integ2, integ3;
	logic [ncocic_pkg::ACC_W-1:0]           comb_dly1, comb_dly2, comb_dly3;
	logic [31:0]                            osc_mem [OSC_WORDS];
	bit                                     osc_loaded [OSC_WORDS];
	int unsigned                            rd_phase;
	int unsigned                            words_seen;
	logic [ncocic_pkg::POS_W-1:0]           slot_next;

	dec_out_t    pending_out [$];
	int          mismatches;
	int          n_beats, n_loads, n_outputs, n_settings, n_in_held;
	int          idle_run;
	int          burst_left;
	bit          hold_off_req;

	nco_mix_cic3_decimator #(
		.OSC_WORDS(OSC_WORDS),
		.OUT_DEPTH(OUT_DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.sample_first (sample_first),
		.sample_second(sample_second),
		.table_slot   (table_slot),
		.osc_first    (osc_first),
		.osc_second   (osc_second),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.filtered     (filtered),
		.position     (position),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int clamp_s16(input int v);
		if (v > 32767) begin
			return 32767;
		end
		if (v < -32768) begin
			return -32768;
		end
		return v;
	endfunction

	// favor the extremes and small magnitudes, otherwise any 16-bit value
	function automatic logic [15:0] pick_value();
		int sel;
		sel = $urandom_range(0, 7);
		case (sel)
			0: begin
				return 16'h8000;
			end
			1: begin
				return 16'h7fff;
			end
			2: begin
				return 16'($urandom_range(0, 63)) - 16'd32;
			end
			default: begin
				return 16'($urandom);
			end
		endcase
	endfunction

	// Advance the predictor by one accepted beat; got is set when a decimated sample is due.
	task automatic mix_decimate(input ncocic_pkg::op_t op, input logic signed [15:0] s1, s2,
			input logic [ncocic_pkg::SLOT_W-1:0] slot, input logic [15:0] o1, o2,
			output bit got, output dec_out_t res);
		int                           d1, d2, p1, p2, scaled;
		logic signed [15:0]           w_lo, w_hi;
		logic [ncocic_pkg::ACC_W-1:0] e0, e1, e2;
		got = 1'b0;
		res = '0;
		if (op == ncocic_pkg::OP_LOAD) begin
			osc_mem[slot] = {o2, o1};
			osc_loaded[slot] = 1'b1;
		end else begin
			d1 = clamp_s16(int'(s1) - int'(ofs_first));
			d2 = clamp_s16(int'(s2) - int'(ofs_second));
			w_lo = osc_mem[rd_phase][15:0];
			w_hi = osc_mem[rd_phase][31:16];
			p1 = d1 * int'(w_lo);
			p2 = d2 * int'(w_hi);
			integ1 = integ1 + p1 + p2;
			integ2 = integ2 + integ1;
			integ3 = integ3 + integ2;
			rd_phase = (rd_phase + 1) % OSC_WORDS;
			words_seen++;
			// run the comb once the block is complete
			if (words_seen >= block_words) begin
				words_seen = 0;
				e0 = comb_dly1 - integ3;
				comb_dly1 = integ3;
				e1 = comb_dly2 - e0;
				comb_dly2 = e0;
				e2 = comb_dly3 - e1;
				comb_dly3 = e1;
				scaled = $signed(e2) >>> (16 - gain_sel);
				res.filt = 16'(clamp_s16(scaled));
				res.pos = slot_next;
				slot_next = slot_next + 1'b1;
				got = 1'b1;
			end
		end
	endtask

	// Offer one beat in bursts with random gaps; return once it is accepted.
	task automatic offer_beat(input ncocic_pkg::op_t op, input logic [15:0] s1, s2,
			input logic [ncocic_pkg::SLOT_W-1:0] slot, input logic [15:0] o1, o2,
			output bit got, output dec_out_t res);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		operation <= op;
		sample_first <= s1;
		sample_second <= s2;
		table_slot <= slot;
		osc_first <= o1;
		osc_second <= o2;
		do @(posedge clk); while (in_stall);
		n_beats++;
		if (op == ncocic_pkg::OP_LOAD) begin
			n_loads++;
		end
		mix_decimate(op, s1, s2, slot, o1, o2, got, res);
	endtask

	// Drop valid, wait for every expected sample, then let the pipeline empty.
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_out.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input ncocic_pkg::reg_idx_t idx,
			input logic [ncocic_pkg::CFG_DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [15:0] o1, o2,
			input logic [ncocic_pkg::GAIN_W-1:0] g, input logic [ncocic_pkg::WPO_W-1:0] w);
		put_reg(ncocic_pkg::REG_OFFSET_FIRST, o1);
		put_reg(ncocic_pkg::REG_OFFSET_SECOND, o2);
		put_reg(ncocic_pkg::REG_GAIN_BITS, ncocic_pkg::CFG_DATA_W'(g));
		put_reg(ncocic_pkg::REG_WORDS_PER_OUTPUT, ncocic_pkg::CFG_DATA_W'(w));
		cfg_write <= 1'b0;
		ofs_first = o1;
		ofs_second = o2;
		gain_sel = g;
		block_words = w;
		n_settings++;
	endtask

	// main stimulus
	initial begin : stimulus
		bit                            got;
		dec_out_t                      res;
		setting_t                      cur;
		int                            n_items;
		logic [ncocic_pkg::SLOT_W-1:0] slot;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		operation <= ncocic_pkg::OP_LOAD;
		sample_first <= '0;
		sample_second <= '0;
		table_slot <= '0;
		osc_first <= '0;
		osc_second <= '0;
		cfg_write <= 1'b0;
		cfg_index <= ncocic_pkg::REG_OFFSET_FIRST;
		cfg_data <= '0;
		ofs_first = '0;
		ofs_second = '0;
		gain_sel = 3'd5;
		block_words = 9'd8;
		integ1 = '0;
		integ2 = '0;
		integ3 = '0;
		comb_dly1 = '0;
		comb_dly2 = '0;
		comb_dly3 = '0;
		rd_phase = 0;
		words_seen = 0;
		slot_next = '0;
		for (int i = 0; i < OSC_WORDS; i++) begin
			osc_loaded[i] = 1'b0;
			osc_mem[i] = '0;
		end
		burst_left = 0;
		hold_off_req = 1'b0;
		n_settings = 1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats under the reset settings
		for (int i = 0; i < N_DIRECTED; i++) begin
			offer_beat(DIRECTED[i].op, DIRECTED[i].s1, DIRECTED[i].s2, DIRECTED[i].slot,
				DIRECTED[i].o1, DIRECTED[i].o2, got, res);
			if (DIRECTED[i].has_exp) begin
				got = 1'b1;
				res.filt = DIRECTED[i].exp_f;
				res.pos = DIRECTED[i].exp_p;
			end
			if (got) begin
				pending_out.push_back(res);
			end
		end

		// random beats, one register setting at a time
		for (int k = 0; k < N_SETTINGS; k++) begin
			cur = SETTINGS[k];
			if (cur.rnd) begin
				cur.ofs1 = pick_value();
				cur.ofs2 = pick_value();
				cur.gain = ncocic_pkg::GAIN_W'($urandom_range(0, 7));
				cur.wpo = ncocic_pkg::WPO_W'($urandom_range(1, 12));
			end
			settle();
			apply_setting(cur.ofs1, cur.ofs2, cur.gain, cur.wpo);
			hold_off_req = cur.press;
			n_items = cur.press ? 300 : (cur.wpo > 32 ? cur.wpo + cur.wpo / 2 + 10 : 110);
			for (int n = 0; n < n_items; n++) begin
				// load the entry about to be read if it was never written, and now and then a random entry
				if (!osc_loaded[rd_phase] || $urandom_range(0, 99) < 12) begin
					slot = osc_loaded[rd_phase]
						? ncocic_pkg::SLOT_W'($urandom_range(0, OSC_WORDS - 1))
						: ncocic_pkg::SLOT_W'(rd_phase);
					offer_beat(ncocic_pkg::OP_LOAD, pick_value(), pick_value(), slot,
						pick_value(), pick_value(), got, res);
				end else begin
					offer_beat(ncocic_pkg::OP_PROCESS, pick_value(), pick_value(),
						ncocic_pkg::SLOT_W'($urandom_range(0, OSC_WORDS - 1)),
						pick_value(), pick_value(), got, res);
				end
				if (got) begin
					pending_out.push_back(res);
				end
			end
		end

		settle();
		$display("Sent %0d beats (%0d table loads) over %0d register settings.",
			n_beats, n_loads, n_settings);
		$display("Checked %0d decimated samples; input stalled for %0d cycles.",
			n_outputs, n_in_held);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Stall the output on segments of varying density; hold off once on request.
	initial begin : receiver
		int seg;
		int pct;
		out_stall <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF) @(posedge clk);
			end
			case ($urandom_range(0, 3))
				0: pct = 0;
				1: pct = 20;
				2: pct = 50;
				default: pct = 85;
			endcase
			seg = $urandom_range(1, 60);
			repeat (seg) begin
				out_stall <= ($urandom_range(0, 99) < pct);
				@(posedge clk);
			end
		end
	end

	// compare each output beat with the oldest expected sample
	always @(posedge clk) begin : check_out
		dec_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_outputs++;
			if (pending_out.size() == 0) begin
				if (mismatches < 10) begin
					$display("unexpected output at %0t: filtered %0d position %0d",
						$time, filtered, position);
				end
				mismatches++;
			end else begin
				want = pending_out.pop_front();
				if (filtered !== want.filt || position !== want.pos) begin
					if (mismatches < 10) begin
						$display("mismatch at %0t: filtered exp %0d got %0d, position exp %0d got %0d",
							$time, want.filt, filtered, want.pos, position);
					end
					mismatches++;
				end
			end
		end
	end

	// end the run if nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_stall) begin
				n_in_held++;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
				idle_run <= 0;
			end else begin
				idle_run <= idle_run + 1;
			end
			if (idle_run >= WATCHDOG_LIMIT) begin
				$display("timeout: no beat moved for %0d cycles", idle_run);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

endmodule
